@@ design/u8dec_pkg.sv @@
// Shared types and constants of the legacy UTF-8 stream decoder.
package u8dec_pkg;

    // Width of the internal saturating count of non-continuation bytes (8..32).
    localparam int COUNT_WIDTH = 16;

    localparam int CP_W    = 31;
    localparam int LEN_W   = 3;
    localparam int CHAR_W  = 16;
    localparam int BYTE_W  = 8;
    localparam int LEAD_W  = 5;
    localparam int CONT_W  = 6;

    // Wide enough for both the internal count and the reported count.
    localparam int CMP_W = (COUNT_WIDTH > CHAR_W) ? COUNT_WIDTH : CHAR_W;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [CHAR_W-1:0]      CHAR_MAX  = {CHAR_W{1'b1}};

    typedef enum logic [1:0] {
        KIND_CHAR     = 2'd0,
        KIND_BAD_LEAD = 2'd1,
        KIND_END      = 2'd2,
        KIND_END_OPEN = 2'd3
    } kind_t;

endpackage

@@ design/utf8_stream_decoder_unit.sv @@
// Legacy UTF-8 (up to six bytes per character) stream decoder, top level.
//
// Takes one string byte per request and returns at most one result per byte:
// a decoded character, a bad lead byte, or the end of the string (zero byte),
// always with the running count of non-continuation bytes. The sequence state
// update and the result are formed from the input byte in a single pass and
// land in the output register at the accepting edge, so a byte can be accepted
// every cycle while the output register is empty or being drained in the same
// cycle. Bytes that open or extend a multi-byte sequence give no result until
// the sequence's last byte arrives.
module utf8_stream_decoder_unit
    import u8dec_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [BYTE_W-1:0] data_byte,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        kind,
    output logic [CP_W-1:0]   code_point,
    output logic [LEN_W-1:0]  sequence_length,
    output logic [CHAR_W-1:0] char_count
);

    logic [LEN_W-1:0]       rem_reg, rem_next;
    logic [CP_W-1:0]        acc_reg, acc_next;
    logic [LEN_W-1:0]       len_reg, len_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;

    logic                   out_valid_reg, out_valid_next;
    kind_t                  kind_reg, kind_next;
    logic [CP_W-1:0]        cp_reg, cp_next;
    logic [LEN_W-1:0]       seq_len_reg, seq_len_next;
    logic [CHAR_W-1:0]      char_count_reg, char_count_next;

    logic                   accept;
    logic                   emit;
    logic                   is_cont;
    logic [COUNT_WIDTH-1:0] count_inc;
    logic [CMP_W-1:0]       count_ext;
    logic [CHAR_W-1:0]      count_shown;
    logic [CP_W-1:0]        acc_shift;
    logic [LEN_W-1:0]       lead_len;
    logic [LEAD_W-1:0]      lead_payload;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // Top bits 10 mark a continuation byte; those are not counted.
    assign is_cont   = (data_byte[7:6] == 2'b10);
    assign count_inc = (data_byte != '0 && !is_cont && count_reg != COUNT_MAX)
                       ? count_reg + 1'b1 : count_reg;
    assign count_ext   = CMP_W'(count_inc);
    assign count_shown = (count_ext > CMP_W'(CHAR_MAX)) ? CHAR_MAX
                                                        : count_ext[CHAR_W-1:0];

    assign acc_shift = {acc_reg[CP_W-CONT_W-1:0], data_byte[CONT_W-1:0]};

    // Lead byte decode; a zero length flags a bad lead.
    always_comb
    begin
        lead_len     = '0;
        lead_payload = '0;
        unique case (data_byte) inside
            8'b110?_????:
            begin
                lead_len     = LEN_W'(2);
                lead_payload = data_byte[4:0];
            end
            8'b1110_????:
            begin
                lead_len     = LEN_W'(3);
                lead_payload = LEAD_W'(data_byte[3:0]);
            end
            8'b1111_0???:
            begin
                lead_len     = LEN_W'(4);
                lead_payload = LEAD_W'(data_byte[2:0]);
            end
            8'b1111_10??:
            begin
                lead_len     = LEN_W'(5);
                lead_payload = LEAD_W'(data_byte[1:0]);
            end
            8'b1111_110?:
            begin
                lead_len     = LEN_W'(6);
                lead_payload = LEAD_W'(data_byte[0]);
            end
            default:
            begin
                lead_len     = '0;
                lead_payload = '0;
            end
        endcase
    end

    always_comb
    begin
        rem_next        = rem_reg;
        acc_next        = acc_reg;
        len_next        = len_reg;
        count_next      = count_reg;
        emit            = 1'b0;
        kind_next       = KIND_CHAR;
        cp_next         = '0;
        seq_len_next    = '0;
        char_count_next = count_shown;

        if (accept)
        begin
            if (data_byte == '0)
            begin
                emit            = 1'b1;
                kind_next       = (rem_reg != '0) ? KIND_END_OPEN : KIND_END;
                char_count_next = count_shown;
                rem_next        = '0;
                acc_next        = '0;
                len_next        = '0;
                count_next      = '0;
            end
            else
            begin
                count_next = count_inc;
                if (rem_reg != '0)
                begin
                    // Any nonzero byte is taken as a continuation here.
                    rem_next = rem_reg - 1'b1;
                    if (rem_reg == LEN_W'(1))
                    begin
                        emit         = 1'b1;
                        kind_next    = KIND_CHAR;
                        cp_next      = acc_shift;
                        seq_len_next = len_reg;
                        acc_next     = '0;
                        len_next     = '0;
                    end
                    else
                    begin
                        acc_next = acc_shift;
                    end
                end
                else if (!data_byte[7])
                begin
                    emit         = 1'b1;
                    kind_next    = KIND_CHAR;
                    cp_next      = CP_W'(data_byte);
                    seq_len_next = LEN_W'(1);
                end
                else if (lead_len == '0)
                begin
                    emit      = 1'b1;
                    kind_next = KIND_BAD_LEAD;
                end
                else
                begin
                    acc_next = CP_W'(lead_payload);
                    len_next = lead_len;
                    rem_next = lead_len - 1'b1;
                end
            end
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg       <= '0;
            acc_reg       <= '0;
            len_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rem_reg       <= rem_next;
            acc_reg       <= acc_next;
            len_reg       <= len_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            kind_reg       <= kind_next;
            cp_reg         <= cp_next;
            seq_len_reg    <= seq_len_next;
            char_count_reg <= char_count_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign kind            = kind_reg;
    assign code_point      = cp_reg;
    assign sequence_length = seq_len_reg;
    assign char_count      = char_count_reg;

`ifndef SYNTHESIS
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg <= LEN_W'(5))
        else $error("open sequence owes more than five bytes");

    a_len_covers_rem: assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg != '0 |-> len_reg > rem_reg)
        else $error("sequence length not above bytes remaining");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && data_byte == '0 |=> rem_reg == '0 && count_reg == '0)
        else $error("state not cleared after end of string");

    a_non_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && kind_reg != KIND_CHAR |-> cp_reg == '0 && seq_len_reg == '0)
        else $error("non-character result carries a code point");

    a_char_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && kind_reg == KIND_CHAR |-> seq_len_reg != '0)
        else $error("character result with zero length");
`endif

endmodule

@@ test/testbench.sv @@
// Self-checking testbench of the legacy UTF-8 stream decoder.
module testbench
    import u8dec_pkg::*;
;

    localparam int QUIET_LIMIT = 4000;
    localparam int LONG_HOLD   = 150;
    localparam int TAIL_CYCLES = 10;
    localparam int REPORT_MAX  = 10;

    typedef struct packed {
        kind_t             kind;
        logic [CP_W-1:0]   cp;
        logic [LEN_W-1:0]  len;
        logic [CHAR_W-1:0] count;
    } decode_result_t;

    class utf8_scoreboard;
        logic [LEN_W-1:0]       owed;
        logic [CP_W-1:0]        partial;
        logic [LEN_W-1:0]       open_len;
        logic [COUNT_WIDTH-1:0] nonc_count;
        decode_result_t         pending_q[$];
        int mismatches;
        int results_seen;
        int strings_ended;
        int saturated_ends;

        function new();
            clear_string();
            mismatches = 0;
            results_seen = 0;
            strings_ended = 0;
            saturated_ends = 0;
        endfunction

        function void clear_string();
            owed = '0;
            partial = '0;
            open_len = '0;
            nonc_count = '0;
        endfunction

        function int outstanding();
            return pending_q.size();
        endfunction

        function logic [CHAR_W-1:0] shown_count();
            logic [CMP_W-1:0] wide;
            wide = CMP_W'(nonc_count);
            return (wide > CMP_W'(CHAR_MAX)) ? CHAR_MAX : wide[CHAR_W-1:0];
        endfunction

        function void push_result(kind_t k, logic [CP_W-1:0] cp, logic [LEN_W-1:0] len);
            decode_result_t r;
            r.kind = k;
            r.cp = cp;
            r.len = len;
            r.count = shown_count();
            pending_q.push_back(r);
        endfunction

        // Work out what one accepted string byte should produce.
        function void note_byte(logic [7:0] b);
            logic [LEN_W-1:0] lead_len;
            if (b == 8'h00)
            begin
                push_result((owed != 0) ? KIND_END_OPEN : KIND_END, '0, '0);
                if (nonc_count == COUNT_MAX)
                    saturated_ends++;
                strings_ended++;
                clear_string();
                return;
            end
            if (b[7:6] != 2'b10 && nonc_count != COUNT_MAX)
                nonc_count++;
            // inside a sequence any nonzero byte is taken as a continuation
            if (owed != 0)
            begin
                partial = {partial[CP_W-7:0], b[5:0]};
                owed--;
                if (owed == 0)
                begin
                    push_result(KIND_CHAR, partial, open_len);
                    partial = '0;
                    open_len = '0;
                end
                return;
            end
            if (b[7] == 1'b0)
            begin
                push_result(KIND_CHAR, CP_W'(b), LEN_W'(1));
                return;
            end
            casez (b)
                8'b110?????: lead_len = 3'd2;
                8'b1110????: lead_len = 3'd3;
                8'b11110???: lead_len = 3'd4;
                8'b111110??: lead_len = 3'd5;
                8'b1111110?: lead_len = 3'd6;
                default:     lead_len = 3'd0;
            endcase
            if (lead_len == 0)
            begin
                push_result(KIND_BAD_LEAD, '0, '0);
                return;
            end
            partial = CP_W'(b & (8'hFF >> (int'(lead_len) + 1)));
            open_len = lead_len;
            owed = lead_len - 3'd1;
        endfunction

        function void flag_mismatch(string msg);
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("mismatch %0d: %s", mismatches, msg);
        endfunction

        function void check_result(logic [1:0] k, logic [CP_W-1:0] cp,
                                   logic [LEN_W-1:0] len, logic [CHAR_W-1:0] cnt);
            decode_result_t want;
            results_seen++;
            if (pending_q.size() == 0)
            begin
                flag_mismatch($sformatf(
                    "result with nothing pending: kind=%0d cp=%h len=%0d count=%0d",
                    k, cp, len, cnt));
                return;
            end
            want = pending_q.pop_front();
            if (k !== want.kind || cp !== want.cp || len !== want.len || cnt !== want.count)
                flag_mismatch($sformatf(
                    "expected kind=%0d cp=%h len=%0d count=%0d, got kind=%0d cp=%h len=%0d count=%0d",
                    want.kind, want.cp, want.len, want.count, k, cp, len, cnt));
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [BYTE_W-1:0] data_byte = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [1:0]        kind;
    logic [CP_W-1:0]   code_point;
    logic [LEN_W-1:0]  sequence_length;
    logic [CHAR_W-1:0] char_count;

    utf8_scoreboard sb;
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    bit hold_request = 1'b0;
    int rx_stall_left = 0;
    int long_holds = 0;
    int bytes_sent = 0;
    int quiet_cycles = 0;

    // empty string, ASCII extremes, bad leads, 2/4/6-byte characters, ASCII and
    // lead bytes consumed as continuations, end inside an open sequence
    logic [7:0] directed_q[$] = '{
        8'h00, 8'h01, 8'h7F, 8'h80, 8'hFF, 8'hFE, 8'hC3, 8'hA9,
        8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hE0, 8'hF5,
        8'h40, 8'hF0, 8'h90, 8'h80, 8'h80, 8'h00, 8'hC2, 8'h00
    };

    utf8_stream_decoder_unit u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .data_byte       (data_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .kind            (kind),
        .code_point      (code_point),
        .sequence_length (sequence_length),
        .char_count      (char_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result side: random stall bursts plus the requested long hold-off
    always @(negedge clk)
    begin
        if (hold_request)
        begin
            rx_stall_left = LONG_HOLD;
            hold_request = 1'b0;
            long_holds++;
        end
        if (rx_stall_left > 0)
        begin
            out_ready = 1'b0;
            rx_stall_left--;
        end
        else if (rx_idle_on && $urandom_range(0, 4) == 0)
        begin
            out_ready = 1'b0;
            rx_stall_left = $urandom_range(1, 6) - 1;
        end
        else
            out_ready = 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_result(kind, code_point, sequence_length, char_count);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT)
                begin
                    $display("watchdog: no request moved for %0d cycles", quiet_cycles);
                    $display("[FAIL] regression broken");
                    $finish;
                end
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        @(negedge clk);
        in_valid = 1'b1;
        data_byte = b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_byte(b);
        bytes_sent++;
        if (tx_idle_on && $urandom_range(0, 4) == 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            data_byte = 8'($urandom);
            repeat ($urandom_range(1, 6) - 1)
                @(negedge clk);
        end
    endtask

    task automatic send_lead(input int len);
        send_byte(8'((8'hFF << (8 - len)) | ($urandom & (8'hFF >> (len + 1)))));
    endtask

    // mostly proper continuations, now and then any nonzero byte
    task automatic send_continuation();
        if ($urandom_range(0, 7) == 0)
            send_byte(8'($urandom_range(1, 255)));
        else
            send_byte(8'h80 | 8'($urandom_range(0, 63)));
    endtask

    task automatic send_random_string();
        int n;
        int pick;
        int len;
        n = $urandom_range(0, 10);
        repeat (n)
        begin
            pick = $urandom_range(0, 19);
            len = $urandom_range(1, 6);
            if (pick < 14)
            begin
                if (len == 1)
                    send_byte(8'($urandom_range(1, 127)));
                else
                begin
                    send_lead(len);
                    repeat (len - 1)
                        send_continuation();
                end
            end
            else if (pick < 16)
                send_byte(($urandom_range(0, 3) == 0) ? 8'($urandom_range(254, 255))
                                                      : 8'($urandom_range(128, 191)));
            else if (pick < 18)
                send_byte(8'($urandom_range(1, 255)));
            else
            begin
                // sequence cut short; what follows gets swallowed into it
                len = $urandom_range(2, 6);
                send_lead(len);
                repeat ($urandom_range(0, len - 2))
                    send_continuation();
            end
        end
        send_byte(8'h00);
    endtask

    // stop offering requests, then wait until every expected result is out
    task automatic wait_for_drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        sb = new();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_q[i])
            send_byte(directed_q[i]);
        wait_for_drain();

        // keep offering requests while the result side is held off
        @(posedge clk);
        hold_request = 1'b1;
        repeat (4) send_random_string();
        while (bytes_sent < 1000)
            send_random_string();

        wait_for_drain();
        while (bytes_sent < 1650)
            send_random_string();

        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        while (bytes_sent < 1920)
            send_random_string();

        @(negedge clk);
        in_valid = 1'b0;
        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Decoded %0d bytes in %0d strings, %0d results checked, %0d mismatches",
                 bytes_sent, sb.strings_ended, sb.results_seen, sb.mismatches);
        $display("Long result hold-offs: %0d, strings ended at the count ceiling: %0d",
                 long_holds, sb.saturated_ends);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
